FILE: src/json_stream_validator_core_macros.svh
// Assertion macros for the JSON stream validator.
// Expects clk_i and rst_ni in the scope of use.
`ifndef JSON_STREAM_VALIDATOR_CORE_MACROS_SVH
`define JSON_STREAM_VALIDATOR_CORE_MACROS_SVH

`define JSV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define JSV_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: src/jsv_pkg.sv
// Types, codes and constant tables of the JSON stream validator.
// No dependencies.
package jsv_pkg;

  localparam int unsigned MaxNestingDef = 64;
  localparam int unsigned OffsetBitsDef = 32;

  typedef enum logic [4:0] {
    PH_VALUE, PH_OBJ_FIRST, PH_ARR_FIRST, PH_KEY, PH_COLON, PH_AFTER, PH_STR, PH_ESC,
    PH_HEX, PH_LIT, PH_N_SIGN, PH_N_ZERO, PH_N_INT, PH_N_DOT, PH_N_FRAC, PH_N_E,
    PH_N_ESIGN, PH_N_EXP, PH_DONE
  } phase_e;

  typedef enum logic [3:0] {
    EV_NONE, EV_OPEN_OBJ, EV_OPEN_ARR, EV_CLOSE_OBJ, EV_CLOSE_ARR, EV_STR_START,
    EV_STR_DATA, EV_STR_END, EV_LIT, EV_NUM, EV_COLON, EV_COMMA, EV_OK, EV_ERR
  } event_e;

  typedef enum logic [1:0] {
    ERR_NONE, ERR_INVALID, ERR_NO_NAME, ERR_UNSUP
  } err_e;

  typedef enum logic [1:0] {
    CMP_EQUAL, CMP_BELOW, CMP_ABOVE
  } cmp_e;

  typedef struct packed {
    logic       is_end;
    logic [7:0] byte_v;
    logic       ws;
    logic       digit;
    logic [4:0] hex;
  } item_t;

  function automatic logic [3:0] int_limit(input logic [4:0] idx);
    case (idx)
      5'd0: int_limit = 4'd9;  5'd1: int_limit = 4'd2;  5'd2: int_limit = 4'd2;
      5'd3: int_limit = 4'd3;  5'd4: int_limit = 4'd3;  5'd5: int_limit = 4'd7;
      5'd6: int_limit = 4'd2;  5'd7: int_limit = 4'd0;  5'd8: int_limit = 4'd3;
      5'd9: int_limit = 4'd6;  5'd10: int_limit = 4'd8; 5'd11: int_limit = 4'd5;
      5'd12: int_limit = 4'd4; 5'd13: int_limit = 4'd7; 5'd14: int_limit = 4'd7;
      5'd15: int_limit = 4'd5; 5'd16: int_limit = 4'd8; 5'd17: int_limit = 4'd0;
      5'd18: int_limit = 4'd7;
      default: int_limit = 4'd0;
    endcase
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] idx);
    lit_char = 8'h00;
    case (sel)
      2'd0: begin
        case (idx)
          3'd0: lit_char = "n"; 3'd1: lit_char = "u"; 3'd2: lit_char = "l";
          3'd3: lit_char = "l"; default: lit_char = 8'h00;
        endcase
      end
      2'd1: begin
        case (idx)
          3'd0: lit_char = "t"; 3'd1: lit_char = "r"; 3'd2: lit_char = "u";
          3'd3: lit_char = "e"; default: lit_char = 8'h00;
        endcase
      end
      2'd2: begin
        case (idx)
          3'd0: lit_char = "f"; 3'd1: lit_char = "a"; 3'd2: lit_char = "l";
          3'd3: lit_char = "s"; 3'd4: lit_char = "e"; default: lit_char = 8'h00;
        endcase
      end
      default: lit_char = 8'h00;
    endcase
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] sel);
    case (sel)
      2'd0: lit_len = 3'd4;
      2'd1: lit_len = 3'd4;
      2'd2: lit_len = 3'd5;
      default: lit_len = 3'd0;
    endcase
  endfunction

endpackage

FILE: src/jsv_ifs.sv
// Stream channels of the JSON stream validator: input words and result words.
// Depends on nothing but the payload widths below.
interface jsv_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_req;
  modport source (output valid, kind, byte_req, input ready);
  modport sink   (input valid, kind, byte_req, output ready);
endinterface

interface jsv_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [7:0]  data;
  logic        is_key;
  logic [1:0]  number_done;
  logic        neg_zero;
  logic [6:0]  depth;
  logic [1:0]  error_code;
  logic [31:0] error_offset;
  modport source (output valid, event_res, data, is_key, number_done, neg_zero,
                  depth, error_code, error_offset, input ready);
  modport sink   (input valid, event_res, data, is_key, number_done, neg_zero,
                  depth, error_code, error_offset, output ready);
endinterface

FILE: src/json_stream_validator_core.sv
// JSON stream validator: takes one document byte per input word and an end word, and
// gives one result word per input word, at one word per clock while result words are
// taken, with no stall of its own; each word passes through the two-word input queue
// and the result register. Nesting up to MAX_NESTING containers is kept in a one-bit
// memory with the top entry and the one below it held in registers, so each byte needs
// one stack write or one registered read. Errors latch; the verdict repeats until reset.
// Depends on jsv_pkg, jsv_ifs, jsv_front, jsv_back and the assertion macros.
`include "json_stream_validator_core_macros.svh"

module json_stream_validator_core import jsv_pkg::*; #(
  parameter int unsigned MAX_NESTING = MaxNestingDef,
  parameter int unsigned OFFSET_BITS = OffsetBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  jsv_in_if.sink     in_if,
  jsv_out_if.source  out_if
);

  logic  item_valid, item_ready;
  item_t item;
  logic  res_err, res_ok;

  assign res_err = out_if.valid && out_if.event_res == EV_ERR;
  assign res_ok  = out_if.valid && out_if.event_res == EV_OK;

  jsv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  jsv_back #(
    .MAX_NESTING (MAX_NESTING),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .out_if       (out_if)
  );

  `JSV_ASSERT(a_err_has_code, !res_err || out_if.error_code != ERR_NONE, "error without code")
  `JSV_ASSERT(a_depth_bound, !out_if.valid || 32'(out_if.depth) <= MAX_NESTING, "depth over limit")
  `JSV_ASSERT_NEXT(a_err_sticky, res_err && out_if.ready, !res_ok, "ok after error")

endmodule

FILE: src/jsv_front.sv
// Front end: accepts input words, classifies the byte, queues two words.
// Depends on jsv_pkg and jsv_in_if.
module jsv_front import jsv_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  jsv_in_if.sink in_if,
  output logic   item_valid_o,
  output item_t  item_o,
  input  logic   item_ready_i
);

  item_t      buf_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  item_t      cls;

  function automatic logic [4:0] hex_of(input logic [7:0] b);
    if (b >= "0" && b <= "9") hex_of = {1'b0, b[3:0]};
    else if (b >= "a" && b <= "f") hex_of = 5'(b - "a" + 8'd10);
    else if (b >= "A" && b <= "F") hex_of = 5'(b - "A" + 8'd10);
    else hex_of = 5'd16;
  endfunction

  always_comb begin
    cls.is_end = in_if.kind;
    cls.byte_v = in_if.byte_req;
    cls.ws     = !in_if.kind && (in_if.byte_req == " " || in_if.byte_req == 8'h09 ||
                                 in_if.byte_req == 8'h0A || in_if.byte_req == 8'h0D);
    cls.digit  = in_if.byte_req >= "0" && in_if.byte_req <= "9";
    cls.hex    = hex_of(in_if.byte_req);
  end

  assign in_if.ready  = cnt_q != 2'd2;
  assign push         = in_if.valid && in_if.ready;
  assign item_valid_o = cnt_q != 2'd0;
  assign item_o       = buf_q[rptr_q];
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop) rptr_q <= !rptr_q;
      cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
    end
  end

endmodule

FILE: src/jsv_back.sv
// Back end: syntax state machine, nesting stack and result register.
// Depends on jsv_pkg and jsv_out_if.
module jsv_back import jsv_pkg::*; #(
  parameter int unsigned MAX_NESTING = MaxNestingDef,
  parameter int unsigned OFFSET_BITS = OffsetBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  item_t      item_i,
  output logic       item_ready_o,
  jsv_out_if.source  out_if
);

  localparam int unsigned CW = $clog2(MAX_NESTING + 1);
  localparam int unsigned IW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
  localparam int unsigned OW = OFFSET_BITS;

  logic nest_mem [MAX_NESTING];

  phase_e         phase_q, phase_d;
  logic [1:0]     lsel_q, lsel_d;
  logic [2:0]     lidx_q, lidx_d;
  logic [2:0]     esc_q, esc_d;
  logic [15:0]    cp_q, cp_d;
  logic           neg_q, neg_d, frac_q, frac_d;
  logic [4:0]     dc_q, dc_d;
  cmp_e           cmp_q, cmp_d;
  logic [OW-1:0]  boff_q, boff_d, toff_q, toff_d, eoff_q, eoff_d;
  logic           err_q, err_d, key_q, key_d, over_q, over_d;
  err_e           ecode_q, ecode_d;
  logic [CW-1:0]  count_q, count_d, count_nx, rd_cnt;
  logic           top_q, top_d, below_q;

  logic           ov_q;
  event_e         ev;
  logic [7:0]     dat;
  logic           rkey, nz;
  logic [1:0]     nd;
  logic           advance;
  logic           mem_we;

  assign item_ready_o = !ov_q || out_if.ready;
  assign advance      = item_valid_i && item_ready_o;

  always_comb begin
    logic       e, ws, dig, do_value, do_key, do_after, do_digit, close_pend;
    logic       push_en, push_kind, pop_en, fail_en;
    logic [7:0] b;
    logic [3:0] dv, lim;
    logic [OW-1:0] pos, fail_off;
    err_e       fail_code;
    logic [4:0] h;

    e = item_i.is_end; b = item_i.byte_v; ws = item_i.ws; dig = item_i.digit;
    h = e ? 5'd16 : item_i.hex;
    pos = boff_q;
    do_value = 1'b0; do_key = 1'b0; do_after = 1'b0; do_digit = 1'b0;
    close_pend = 1'b0; push_en = 1'b0; push_kind = 1'b0; pop_en = 1'b0;
    fail_en = 1'b0; fail_code = ERR_INVALID; fail_off = pos;
    dv = b[3:0]; lim = 4'd0;
    mem_we = 1'b0;

    phase_d = phase_q; lsel_d = lsel_q; lidx_d = lidx_q; esc_d = esc_q; cp_d = cp_q;
    neg_d = neg_q; frac_d = frac_q; dc_d = dc_q; cmp_d = cmp_q; boff_d = boff_q;
    toff_d = toff_q; eoff_d = eoff_q; err_d = err_q; key_d = key_q; over_d = over_q;
    ecode_d = ecode_q; count_d = count_q; top_d = top_q;
    ev = EV_NONE; dat = 8'h00; rkey = 1'b0; nd = 2'd0; nz = 1'b0;

    if (phase_q == PH_DONE) begin
      ev = err_q ? EV_ERR : EV_OK;
    end else begin
      if (!e) boff_d = OW'(boff_q + 1'b1);
      case (phase_q)
        PH_VALUE: begin
          if (ws) ev = EV_NONE; else do_value = 1'b1;
        end
        PH_OBJ_FIRST, PH_ARR_FIRST: begin
          if (ws) begin
            ev = EV_NONE;
          end else if (!e && b == ((phase_q == PH_OBJ_FIRST) ? "}" : "]")) begin
            close_pend = 1'b1;
            ev = (phase_q == PH_OBJ_FIRST) ? EV_CLOSE_OBJ : EV_CLOSE_ARR;
            phase_d = PH_AFTER;
          end else if (over_q) begin
            fail_en = 1'b1; fail_code = ERR_UNSUP;
          end else if (phase_q == PH_OBJ_FIRST) begin
            do_key = 1'b1;
          end else begin
            do_value = 1'b1;
          end
        end
        PH_KEY: begin
          if (ws) ev = EV_NONE; else do_key = 1'b1;
        end
        PH_COLON: begin
          if (ws) begin
            ev = EV_NONE;
          end else if (!e && b == ":") begin
            ev = EV_COLON; phase_d = PH_VALUE;
          end else begin
            fail_en = 1'b1;
          end
        end
        PH_AFTER: do_after = 1'b1;
        PH_STR: begin
          if (e) begin
            fail_en = 1'b1;
          end else if (b == "\"") begin
            ev = EV_STR_END; rkey = key_q;
            phase_d = key_q ? PH_COLON : PH_AFTER;
          end else if (b == "\\") begin
            toff_d = pos; phase_d = PH_ESC;
          end else if (b == 8'h00) begin
            fail_en = 1'b1; fail_code = ERR_UNSUP;
          end else if (b < 8'h20) begin
            fail_en = 1'b1;
          end else begin
            ev = EV_STR_DATA; dat = b; rkey = key_q;
          end
        end
        PH_ESC: begin
          if (e) begin
            fail_en = 1'b1; fail_off = toff_q;
          end else if (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
                       b == "n" || b == "r" || b == "t") begin
            ev = EV_STR_DATA; rkey = key_q; phase_d = PH_STR;
            case (b)
              "b": dat = 8'h08;
              "f": dat = 8'h0C;
              "n": dat = 8'h0A;
              "r": dat = 8'h0D;
              "t": dat = 8'h09;
              default: dat = b;
            endcase
          end else if (b == "u") begin
            esc_d = 3'd0; cp_d = 16'h0000; phase_d = PH_HEX;
          end else begin
            fail_en = 1'b1;
          end
        end
        PH_HEX: begin
          if (h[4]) begin
            fail_en = 1'b1;
          end else begin
            cp_d  = {cp_q[11:0], h[3:0]};
            esc_d = 3'(esc_q + 1'b1);
            if (esc_d >= 3'd4) begin
              if (cp_d == 16'h0000 || cp_d > 16'd127) begin
                fail_en = 1'b1; fail_code = ERR_UNSUP; fail_off = toff_q;
              end else begin
                ev = EV_STR_DATA; dat = cp_d[7:0]; rkey = key_q; phase_d = PH_STR;
              end
            end
          end
        end
        PH_LIT: begin
          if (e || lsel_q > 2'd2 || lidx_q >= lit_len(lsel_q) ||
              b != lit_char(lsel_q, lidx_q)) begin
            fail_en = 1'b1; fail_off = toff_q;
          end else begin
            lidx_d = 3'(lidx_q + 1'b1);
            if (lidx_d == lit_len(lsel_q)) begin
              ev = EV_LIT; phase_d = PH_AFTER;
            end
          end
        end
        PH_N_SIGN: begin
          if (e) begin
            fail_en = 1'b1; fail_off = toff_q;
          end else if (dig) begin
            do_digit = 1'b1;
            phase_d = (b == "0") ? PH_N_ZERO : PH_N_INT;
            ev = EV_NUM;
          end else begin
            fail_en = 1'b1;
          end
        end
        PH_N_DOT, PH_N_ESIGN: begin
          if (!e && dig) begin
            phase_d = (phase_q == PH_N_DOT) ? PH_N_FRAC : PH_N_EXP;
            ev = EV_NUM;
          end else begin
            fail_en = 1'b1;
          end
        end
        PH_N_E: begin
          if (!e && (b == "+" || b == "-")) begin
            phase_d = PH_N_ESIGN; ev = EV_NUM;
          end else if (!e && dig) begin
            phase_d = PH_N_EXP; ev = EV_NUM;
          end else begin
            fail_en = 1'b1;
          end
        end
        PH_N_ZERO, PH_N_INT, PH_N_FRAC, PH_N_EXP: begin
          if (!e && dig) begin
            if (phase_q == PH_N_ZERO) begin
              fail_en = 1'b1;
            end else begin
              do_digit = (phase_q == PH_N_INT);
              ev = EV_NUM;
            end
          end else if (!e && b == "." && (phase_q == PH_N_ZERO || phase_q == PH_N_INT)) begin
            frac_d = 1'b1; phase_d = PH_N_DOT; ev = EV_NUM;
          end else if (!e && (b == "e" || b == "E") && phase_q != PH_N_EXP) begin
            frac_d = 1'b1; phase_d = PH_N_E; ev = EV_NUM;
          end else if (frac_q) begin
            nd = 2'd2; do_after = 1'b1;
          end else if (dc_q > 5'd19 || (dc_q == 5'd19 && cmp_q == CMP_ABOVE)) begin
            fail_en = 1'b1; fail_code = ERR_UNSUP; fail_off = toff_q;
          end else begin
            nd = 2'd1; nz = neg_q && (phase_q == PH_N_ZERO); do_after = 1'b1;
          end
        end
        default: fail_en = 1'b1;
      endcase

      if (do_value) begin
        if (e) begin
          fail_en = 1'b1;
        end else if (b == "{") begin
          push_en = 1'b1; push_kind = 1'b0; phase_d = PH_OBJ_FIRST; ev = EV_OPEN_OBJ;
        end else if (b == "[") begin
          push_en = 1'b1; push_kind = 1'b1; phase_d = PH_ARR_FIRST; ev = EV_OPEN_ARR;
        end else if (b == "\"") begin
          key_d = 1'b0; phase_d = PH_STR; ev = EV_STR_START;
        end else if (b == "-" || dig) begin
          toff_d = pos; neg_d = (b == "-"); frac_d = 1'b0; dc_d = 5'd0; cmp_d = CMP_EQUAL;
          if (b == "-") begin
            phase_d = PH_N_SIGN;
          end else begin
            do_digit = 1'b1;
            phase_d = (b == "0") ? PH_N_ZERO : PH_N_INT;
          end
          ev = EV_NUM;
        end else if (b == "n" || b == "t" || b == "f") begin
          toff_d = pos;
          lsel_d = (b == "n") ? 2'd0 : (b == "t") ? 2'd1 : 2'd2;
          lidx_d = 3'd1; phase_d = PH_LIT; ev = EV_NONE;
        end else begin
          fail_en = 1'b1;
        end
      end

      if (do_key) begin
        if (!e && b == "\"") begin
          key_d = 1'b1; phase_d = PH_STR; ev = EV_STR_START; rkey = 1'b1;
        end else begin
          fail_en = 1'b1; fail_code = ERR_NO_NAME;
        end
      end

      if (do_after) begin
        phase_d = PH_AFTER;
        if (e) begin
          if (count_q == '0) begin
            phase_d = PH_DONE; ev = EV_OK;
          end else begin
            fail_en = 1'b1;
          end
        end else if (ws) begin
          ev = EV_NONE;
        end else if (count_q == '0) begin
          fail_en = 1'b1;
        end else if (!top_q && b == "}") begin
          pop_en = 1'b1; ev = EV_CLOSE_OBJ;
        end else if (top_q && b == "]") begin
          pop_en = 1'b1; ev = EV_CLOSE_ARR;
        end else if (b == ",") begin
          phase_d = top_q ? PH_VALUE : PH_KEY; ev = EV_COMMA;
        end else begin
          fail_en = 1'b1;
        end
      end

      if (do_digit && dc_d < 5'd19) begin
        lim = int_limit(dc_d);
        if (dc_d == 5'd18 && neg_d) lim = 4'(lim + 1'b1);
        if (cmp_d == CMP_EQUAL) begin
          if (dv < lim) cmp_d = CMP_BELOW;
          else if (dv > lim) cmp_d = CMP_ABOVE;
        end
        dc_d = 5'(dc_d + 1'b1);
      end else if (do_digit && dc_d < 5'd31) begin
        dc_d = 5'(dc_d + 1'b1);
      end

      if (close_pend) begin
        if (over_q) over_d = 1'b0;
        else if (count_q != '0) pop_en = 1'b1;
      end

      if (push_en) begin
        if (count_q < CW'(MAX_NESTING)) begin
          mem_we = advance; count_d = CW'(count_q + 1'b1); top_d = push_kind;
          over_d = 1'b0;
        end else begin
          over_d = 1'b1;
        end
      end
      if (pop_en) begin
        count_d = CW'(count_q - 1'b1); top_d = below_q;
      end

      if (fail_en) begin
        err_d = 1'b1; ecode_d = fail_code; eoff_d = fail_off; phase_d = PH_DONE;
        ev = EV_ERR;
      end
    end
  end

  assign count_nx = advance ? count_d : count_q;
  assign rd_cnt   = CW'(count_nx - CW'(2));

  always_ff @(posedge clk_i) begin
    if (mem_we) nest_mem[count_q[IW-1:0]] <= top_d;
    below_q <= nest_mem[rd_cnt[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_VALUE; lsel_q <= 2'd0; lidx_q <= 3'd0; esc_q <= 3'd0; cp_q <= '0;
      neg_q <= 1'b0; frac_q <= 1'b0; dc_q <= 5'd0; cmp_q <= CMP_EQUAL;
      boff_q <= '0; toff_q <= '0; eoff_q <= '0; err_q <= 1'b0; key_q <= 1'b0;
      over_q <= 1'b0; ecode_q <= ERR_NONE; count_q <= '0; top_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (advance) begin
        phase_q <= phase_d; lsel_q <= lsel_d; lidx_q <= lidx_d; esc_q <= esc_d;
        cp_q <= cp_d; neg_q <= neg_d; frac_q <= frac_d; dc_q <= dc_d; cmp_q <= cmp_d;
        boff_q <= boff_d; toff_q <= toff_d; eoff_q <= eoff_d; err_q <= err_d;
        key_q <= key_d; over_q <= over_d; ecode_q <= ecode_d; count_q <= count_d;
        top_q <= top_d;
        ov_q <= 1'b1;
      end else if (out_if.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic [63:0] off_ext;
    off_ext = 64'(eoff_d);
    if (advance) begin
      out_if.event_res    <= ev;
      out_if.data         <= dat;
      out_if.is_key       <= rkey;
      out_if.number_done  <= nd;
      out_if.neg_zero     <= nz;
      out_if.depth        <= 7'(count_d);
      out_if.error_code   <= (ev == EV_ERR) ? ecode_d : ERR_NONE;
      out_if.error_offset <= (ev == EV_ERR) ? off_ext[31:0] : 32'h0;
    end
  end

  assign out_if.valid = ov_q;

endmodule

FILE: verif/json_stream_validator_core_tb.sv
// Self-checking testbench for json_stream_validator_core: streams one JSON document
// byte by byte with random idling on both channels and checks every result word.
// Depends on jsv_pkg, jsv_ifs and the core RTL.
`timescale 1ns / 1ps

module json_stream_validator_core_tb;
  import jsv_pkg::*;

  typedef struct {
    bit       is_end;
    bit [7:0] b;
  } doc_word_t;

  typedef struct {
    event_e    ev;
    bit [7:0]  data;
    bit        key;
    bit [1:0]  ndone;
    bit        nzero;
    bit [6:0]  depth;
    err_e      code;
    bit [31:0] off;
  } token_t;

  localparam int NestMax = 64;
  localparam int IdleLimit = 5000;
  localparam byte unsigned DigitLim[19] = '{9, 2, 2, 3, 3, 7, 2, 0, 3, 6, 8, 5, 4, 7, 7, 5,
                                            8, 0, 7};

  logic clk_i;
  logic rst_ni;

  jsv_in_if  in_ch();
  jsv_out_if out_ch();

  json_stream_validator_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  doc_word_t doc_q[$];
  token_t    token_q[$];
  string     lit_words[3] = '{"null", "true", "false"};
  int        mismatches = 0;
  bit        in_took, out_took;
  int        in_gap, rdy_gap, idle_cycles;

  // parser state of the predictor
  bit [NestMax-1:0] kinds;
  int        nest_n;
  phase_e    ph;
  bit [4:0]  lit_prog;
  bit [2:0]  esc_n;
  bit [15:0] cp;
  bit [1:0]  nflags;
  int        dcount;
  cmp_e      cmp;
  bit [31:0] boff, toff, err_off;
  bit        err_lat, in_key, over;
  err_e      err_cd;
  token_t    tok;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic bit is_blank(bit [7:0] b);
    return b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0D;
  endfunction

  function automatic bit is_num(bit [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic void fail_at(err_e code, bit [31:0] off);
    err_lat = 1'b1;
    err_cd = code;
    err_off = off;
    ph = PH_DONE;
    tok.ev = EV_ERR;
  endfunction

  function automatic void push_kind(bit k);
    if (nest_n < NestMax) begin
      kinds[nest_n] = k;
      nest_n++;
      over = 1'b0;
    end else begin
      over = 1'b1;
    end
  endfunction

  function automatic void int_digit(int d);
    int lim;
    if (dcount < 19) begin
      if (cmp == CMP_EQUAL) begin
        lim = int'(DigitLim[dcount]);
        if (dcount == 18 && nflags[0]) lim++;
        if (d < lim) cmp = CMP_BELOW;
        else if (d > lim) cmp = CMP_ABOVE;
      end
      dcount++;
    end else if (dcount < 31) begin
      dcount++;
    end
  endfunction

  function automatic void value_start(bit is_end, bit [7:0] b, bit [31:0] pos);
    if (is_end) begin
      fail_at(ERR_INVALID, pos);
    end else if (b == "{") begin
      push_kind(1'b0);
      ph = PH_OBJ_FIRST;
      tok.ev = EV_OPEN_OBJ;
    end else if (b == "[") begin
      push_kind(1'b1);
      ph = PH_ARR_FIRST;
      tok.ev = EV_OPEN_ARR;
    end else if (b == "\"") begin
      in_key = 1'b0;
      ph = PH_STR;
      tok.ev = EV_STR_START;
    end else if (b == "-" || is_num(b)) begin
      toff = pos;
      nflags = (b == "-") ? 2'd1 : 2'd0;
      dcount = 0;
      cmp = CMP_EQUAL;
      if (b == "-") begin
        ph = PH_N_SIGN;
      end else begin
        int_digit(int'(b - "0"));
        ph = (b == "0") ? PH_N_ZERO : PH_N_INT;
      end
      tok.ev = EV_NUM;
    end else if (b == "n" || b == "t" || b == "f") begin
      toff = pos;
      lit_prog = {(b == "n") ? 2'd0 : (b == "t") ? 2'd1 : 2'd2, 3'd1};
      ph = PH_LIT;
      tok.ev = EV_NONE;
    end else begin
      fail_at(ERR_INVALID, pos);
    end
  endfunction

  function automatic void key_start(bit is_end, bit [7:0] b, bit [31:0] pos);
    if (!is_end && b == "\"") begin
      in_key = 1'b1;
      ph = PH_STR;
      tok.ev = EV_STR_START;
      tok.key = 1'b1;
    end else begin
      fail_at(ERR_NO_NAME, pos);
    end
  endfunction

  function automatic void after_value(bit is_end, bit [7:0] b, bit [31:0] pos);
    bit top;
    ph = PH_AFTER;
    if (is_end) begin
      if (nest_n == 0) begin
        ph = PH_DONE;
        tok.ev = EV_OK;
      end else begin
        fail_at(ERR_INVALID, pos);
      end
    end else if (is_blank(b)) begin
      tok.ev = EV_NONE;
    end else if (nest_n == 0 || nest_n > NestMax) begin
      fail_at(ERR_INVALID, pos);
    end else begin
      top = kinds[nest_n-1];
      if (!top && b == "}") begin
        nest_n--;
        tok.ev = EV_CLOSE_OBJ;
      end else if (top && b == "]") begin
        nest_n--;
        tok.ev = EV_CLOSE_ARR;
      end else if (b == ",") begin
        ph = top ? PH_VALUE : PH_KEY;
        tok.ev = EV_COMMA;
      end else begin
        fail_at(ERR_INVALID, pos);
      end
    end
  endfunction

  function automatic bit end_number();
    if (nflags[1]) begin
      tok.ndone = 2'd2;
      return 1'b1;
    end
    if (dcount > 19 || (dcount == 19 && cmp == CMP_ABOVE)) begin
      fail_at(ERR_UNSUP, toff);
      return 1'b0;
    end
    tok.ndone = 2'd1;
    tok.nzero = nflags[0] && ph == PH_N_ZERO;
    return 1'b1;
  endfunction

  function automatic int hex_of(bit [7:0] b);
    if (is_num(b)) return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return 16;
  endfunction

  function automatic void parser_clear();
    kinds = '0;
    nest_n = 0;
    ph = PH_VALUE;
    lit_prog = '0;
    esc_n = '0;
    cp = '0;
    nflags = '0;
    dcount = 0;
    cmp = CMP_EQUAL;
    boff = '0;
    toff = '0;
    err_lat = 1'b0;
    in_key = 1'b0;
    over = 1'b0;
    err_cd = ERR_NONE;
    err_off = '0;
  endfunction

  function automatic token_t parse_word(bit is_end, bit [7:0] b);
    bit [31:0] pos;
    bit        ws;
    int        d, h, sel, idx;
    pos = boff;
    ws = !is_end && is_blank(b);
    tok.ev = EV_NONE;
    tok.data = '0;
    tok.key = 1'b0;
    tok.ndone = '0;
    tok.nzero = 1'b0;
    if (ph == PH_DONE) begin
      tok.ev = err_lat ? EV_ERR : EV_OK;
    end else begin
      if (!is_end) boff = boff + 32'd1;
      case (ph)
        PH_VALUE: if (!ws) value_start(is_end, b, pos);
        PH_OBJ_FIRST, PH_ARR_FIRST: begin
          if (ws) begin
          end else if (!is_end && b == ((ph == PH_OBJ_FIRST) ? "}" : "]")) begin
            if (over) over = 1'b0;
            else if (nest_n > 0) nest_n--;
            tok.ev = (ph == PH_OBJ_FIRST) ? EV_CLOSE_OBJ : EV_CLOSE_ARR;
            ph = PH_AFTER;
          end else if (over) begin
            fail_at(ERR_UNSUP, pos);
          end else if (ph == PH_OBJ_FIRST) begin
            key_start(is_end, b, pos);
          end else begin
            value_start(is_end, b, pos);
          end
        end
        PH_KEY: if (!ws) key_start(is_end, b, pos);
        PH_COLON: begin
          if (ws) begin
          end else if (!is_end && b == ":") begin
            tok.ev = EV_COLON;
            ph = PH_VALUE;
          end else begin
            fail_at(ERR_INVALID, pos);
          end
        end
        PH_AFTER: after_value(is_end, b, pos);
        PH_STR: begin
          if (is_end) begin
            fail_at(ERR_INVALID, pos);
          end else if (b == "\"") begin
            tok.ev = EV_STR_END;
            tok.key = in_key;
            ph = in_key ? PH_COLON : PH_AFTER;
          end else if (b == "\\") begin
            toff = pos;
            ph = PH_ESC;
          end else if (b == 8'h00) begin
            fail_at(ERR_UNSUP, pos);
          end else if (b < 8'h20) begin
            fail_at(ERR_INVALID, pos);
          end else begin
            tok.ev = EV_STR_DATA;
            tok.data = b;
            tok.key = in_key;
          end
        end
        PH_ESC: begin
          d = 256;
          if (is_end) begin
            fail_at(ERR_INVALID, toff);
          end else begin
            if (b == "\"" || b == "\\" || b == "/") d = int'(b);
            else if (b == "b") d = 8'h08;
            else if (b == "f") d = 8'h0C;
            else if (b == "n") d = 8'h0A;
            else if (b == "r") d = 8'h0D;
            else if (b == "t") d = 8'h09;
            if (d < 256) begin
              tok.ev = EV_STR_DATA;
              tok.data = 8'(d);
              tok.key = in_key;
              ph = PH_STR;
            end else if (b == "u") begin
              esc_n = '0;
              cp = '0;
              ph = PH_HEX;
            end else begin
              fail_at(ERR_INVALID, pos);
            end
          end
        end
        PH_HEX: begin
          h = is_end ? 16 : hex_of(b);
          if (h > 15) begin
            fail_at(ERR_INVALID, pos);
          end else begin
            cp = {cp[11:0], h[3:0]};
            esc_n = 3'(esc_n + 3'd1);
            if (esc_n >= 4) begin
              if (cp == 0 || cp > 127) begin
                fail_at(ERR_UNSUP, toff);
              end else begin
                tok.ev = EV_STR_DATA;
                tok.data = cp[7:0];
                tok.key = in_key;
                ph = PH_STR;
              end
            end
          end
        end
        PH_LIT: begin
          sel = int'(lit_prog[4:3]);
          idx = int'(lit_prog[2:0]);
          if (is_end || sel > 2) begin
            fail_at(ERR_INVALID, toff);
          end else if (idx >= lit_words[sel].len() || b != lit_words[sel][idx]) begin
            fail_at(ERR_INVALID, toff);
          end else begin
            idx++;
            lit_prog = {sel[1:0], idx[2:0]};
            if (idx == lit_words[sel].len()) begin
              tok.ev = EV_LIT;
              ph = PH_AFTER;
            end
          end
        end
        PH_N_SIGN: begin
          if (is_end) begin
            fail_at(ERR_INVALID, toff);
          end else if (is_num(b)) begin
            int_digit(int'(b - "0"));
            ph = (b == "0") ? PH_N_ZERO : PH_N_INT;
            tok.ev = EV_NUM;
          end else begin
            fail_at(ERR_INVALID, pos);
          end
        end
        PH_N_DOT, PH_N_ESIGN: begin
          if (!is_end && is_num(b)) begin
            ph = (ph == PH_N_DOT) ? PH_N_FRAC : PH_N_EXP;
            tok.ev = EV_NUM;
          end else begin
            fail_at(ERR_INVALID, pos);
          end
        end
        PH_N_E: begin
          if (!is_end && (b == "+" || b == "-")) begin
            ph = PH_N_ESIGN;
            tok.ev = EV_NUM;
          end else if (!is_end && is_num(b)) begin
            ph = PH_N_EXP;
            tok.ev = EV_NUM;
          end else begin
            fail_at(ERR_INVALID, pos);
          end
        end
        PH_N_ZERO, PH_N_INT, PH_N_FRAC, PH_N_EXP: begin
          if (!is_end && is_num(b)) begin
            if (ph == PH_N_ZERO) begin
              fail_at(ERR_INVALID, pos);
            end else begin
              if (ph == PH_N_INT) int_digit(int'(b - "0"));
              tok.ev = EV_NUM;
            end
          end else if (!is_end && b == "." && (ph == PH_N_ZERO || ph == PH_N_INT)) begin
            nflags[1] = 1'b1;
            ph = PH_N_DOT;
            tok.ev = EV_NUM;
          end else if (!is_end && (b == "e" || b == "E") && ph != PH_N_EXP) begin
            nflags[1] = 1'b1;
            ph = PH_N_E;
            tok.ev = EV_NUM;
          end else if (end_number()) begin
            after_value(is_end, b, pos);
          end
        end
        default: fail_at(ERR_INVALID, pos);
      endcase
    end
    tok.depth = nest_n[6:0];
    tok.code = (tok.ev == EV_ERR) ? err_cd : ERR_NONE;
    tok.off = (tok.ev == EV_ERR) ? err_off : '0;
    return tok;
  endfunction

  // document generation
  function automatic void put_byte(bit [7:0] b);
    doc_q.push_back('{1'b0, b});
  endfunction

  function automatic void put_text(string s);
    foreach (s[i]) put_byte(s[i]);
  endfunction

  function automatic void put_blank();
    string blanks = " \t\n\r";
    repeat ($urandom_range(0, 2)) put_byte(blanks[$urandom_range(0, 3)]);
  endfunction

  function automatic void put_string();
    string esc = "\"\\/bfnrt";
    string hx = "0123456789abcdefABCDEF";
    bit [7:0] c;
    int v;
    put_byte("\"");
    repeat ($urandom_range(0, 8)) begin
      v = $urandom_range(0, 19);
      if (v < 14) begin
        do c = 8'($urandom_range(8'h20, 8'hFF)); while (c == "\"" || c == "\\");
        put_byte(c);
      end else if (v < 17) begin
        put_byte("\\");
        put_byte(esc[$urandom_range(0, 7)]);
      end else begin
        v = $urandom_range(1, 127);
        put_text("\\u00");
        put_byte(hx[v / 16]);
        put_byte((v % 16 >= 10 && $urandom_range(0, 1)) ? hx[v % 16 + 6] : hx[v % 16]);
      end
    end
    put_byte("\"");
  endfunction

  function automatic void put_number();
    if ($urandom_range(0, 2) == 0) put_byte("-");
    if ($urandom_range(0, 3) == 0) begin
      put_byte("0");
    end else begin
      put_byte(8'("0" + $urandom_range(1, 9)));
      repeat ($urandom_range(0, 17)) put_byte(8'("0" + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 2) == 0) begin
      put_byte(".");
      repeat ($urandom_range(1, 3)) put_byte(8'("0" + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 3) == 0) begin
      put_byte($urandom_range(0, 1) ? "e" : "E");
      case ($urandom_range(0, 2))
        0: put_byte("+");
        1: put_byte("-");
        default: ;
      endcase
      repeat ($urandom_range(1, 3)) put_byte(8'("0" + $urandom_range(0, 9)));
    end
  endfunction

  function automatic void put_value(int lvl);
    int sel, n;
    sel = $urandom_range((lvl < 4) ? 0 : 2, 5);
    case (sel)
      0: begin
        put_byte("{");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) put_byte(",");
          put_blank();
          put_string();
          put_blank();
          put_byte(":");
          put_blank();
          put_value(lvl + 1);
          put_blank();
        end
        put_byte("}");
      end
      1: begin
        put_byte("[");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) put_byte(",");
          put_blank();
          put_value(lvl + 1);
          put_blank();
        end
        put_byte("]");
      end
      2: put_text(lit_words[$urandom_range(0, 2)]);
      3: put_string();
      default: put_number();
    endcase
  endfunction

  function automatic void build_document();
    string bad_tails[7] = '{"9223372036854775808]", "\"\\u0000\"", "\"\\u0080\"",
                            "tru]", "{1:2}", "-]", "\"\\x\""};
    put_text(" [{},[],{\"k\":null,\"\":true},false,0,-0,-0.5e+3,1E9,");
    put_text("9223372036854775807,-9223372036854775808,");
    put_text("\"a\\\"\\\\\\/\\b\\f\\n\\r\\t\\u0001\\u007F\\u007f\",");
    repeat (NestMax) put_byte("[");
    repeat (NestMax) put_byte("]");
    while (doc_q.size() < 480) begin
      put_byte(",");
      put_blank();
      put_value(1);
    end
    case ($urandom_range(0, 5))
      0: begin
        put_byte(",");
        put_text(bad_tails[$urandom_range(0, 6)]);
      end
      1: put_text(",\"ab");
      2: begin
        put_text(",\"a");
        put_byte(8'h00);
      end
      3: begin
        put_byte(",");
        repeat (NestMax) put_byte("{");
        put_byte("1");
      end
      default: begin
        put_byte("]");
        put_blank();
      end
    endcase
    doc_q.push_back('{1'b1, 8'($urandom_range(0, 255))});
    repeat (6) doc_q.push_back('{1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))});
  endfunction

  // stimulus and ready, both driven at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_ch.valid || in_took) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (doc_q.size() > 0 && doc_q.size() > 60 && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 4);
          in_ch.valid <= 1'b0;
        end else if (doc_q.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.kind <= doc_q[0].is_end;
          in_ch.byte_req <= doc_q[0].b;
          void'(doc_q.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      if (rdy_gap > 0) begin
        rdy_gap--;
        out_ch.ready <= 1'b0;
      end else if (doc_q.size() > 60 && $urandom_range(0, 7) == 0) begin
        rdy_gap = $urandom_range(0, 4);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // predict on accepted input words, check accepted result words
  always @(posedge clk_i) begin
    token_t    want;
    bit [31:0] exp_f[8], act_f[8];
    string     names[8];
    in_took = rst_ni && in_ch.valid && in_ch.ready;
    out_took = rst_ni && out_ch.valid && out_ch.ready;
    if (in_took) token_q.push_back(parse_word(in_ch.kind, in_ch.byte_req));
    if (out_took) begin
      if (token_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual event %0d",
                 $time, out_ch.event_res);
        mismatches++;
      end else begin
        want = token_q.pop_front();
        names = '{"event", "data", "is_key", "number_done", "neg_zero", "depth",
                  "error_code", "error_offset"};
        exp_f = '{want.ev, want.data, want.key, want.ndone, want.nzero, want.depth,
                  want.code, want.off};
        act_f = '{out_ch.event_res, out_ch.data, out_ch.is_key, out_ch.number_done,
                  out_ch.neg_zero, out_ch.depth, out_ch.error_code,
                  out_ch.error_offset};
        foreach (names[i]) begin
          if (exp_f[i] !== act_f[i]) begin
            $display("%0t: %s expected %0d actual %0d", $time, names[i], exp_f[i],
                     act_f[i]);
            mismatches++;
          end
        end
      end
    end
    idle_cycles = (in_took || out_took) ? 0 : idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.byte_req = '0;
    out_ch.ready = 1'b0;
    in_took = 1'b0;
    out_took = 1'b0;
    in_gap = 0;
    rdy_gap = 0;
    idle_cycles = 0;
    parser_clear();
    build_document();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (doc_q.size() == 0 && !in_ch.valid);
    wait (token_q.size() == 0);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && token_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
